>>> sv/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/lssc_pkg.sv
package lssc_pkg;

  localparam int SHEETS   = 8;
  localparam int RESERVED = 4;
  localparam int IDX_W    = $clog2(SHEETS);
  localparam int SHEET_W  = 6;
  localparam int STAMP_W  = 32;
  localparam int BANK_W   = 64;
  localparam int OFF_W    = 32;

  localparam logic [1:0] ACT_LOOKUP   = 2'd0;
  localparam logic [1:0] ACT_REGISTER = 2'd1;
  localparam logic [1:0] ACT_TOUCH    = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_NULL     = 3'd2;
  localparam logic [2:0] ST_NOSHEET  = 3'd3;
  localparam logic [2:0] ST_BADINDEX = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic [BANK_W-1:0]  bank_id;
    logic [OFF_W-1:0]   bank_offset;
    logic [SHEET_W-1:0] sheet_index;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SHEET_W-1:0] sheet;
    logic               load_request;
  } rsp_t;

  typedef struct packed {
    logic match;
    logic older;
  } cmp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HIT_SCAN,
    S_VICTIM_SCAN,
    S_FILL,
    S_FINISH
  } state_t;

endpackage

>>> sv/lssc_cmp.sv
module lssc_cmp (
  input  logic [lssc_pkg::BANK_W-1:0]  key_bank,
  input  logic [lssc_pkg::OFF_W-1:0]   key_offset,
  input  logic                         entry_valid,
  input  logic [lssc_pkg::BANK_W-1:0]  entry_bank,
  input  logic [lssc_pkg::OFF_W-1:0]   entry_offset,
  input  logic [lssc_pkg::STAMP_W-1:0] entry_stamp,
  input  logic [lssc_pkg::STAMP_W-1:0] best_stamp,
  output lssc_pkg::cmp_t               result
);
  import lssc_pkg::*;

  always_comb begin
    result.match = entry_valid && (entry_bank == key_bank) && (entry_offset == key_offset);
    result.older = entry_stamp < best_stamp;
  end

endmodule

>>> sv/lru_sheet_slot_cache.sv
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   req_t  {action, bank_id, bank_offset, sheet_index}
// rsp      out  rsp_valid/rsp_stall   rsp_t  {status, sheet, load_request}
//
// One compare unit walks the slots, one slot per cycle. Register, touch, null handle
// and bad index go straight to finish; a lookup walks the slots for a hit, and on a miss
// walks the unreserved slots for a victim and fills it (stopping at the first free slot).
// req_stall is high from acceptance until the result enters the output register.
// A result waiting on rsp_stall holds the next item in finish, with req_stall high. rst
// clears all slot valid bits and the use stamp.
module lru_sheet_slot_cache (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lssc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lssc_pkg::rsp_t rsp
);
  import lssc_pkg::*;

  state_t state, state_next;

  logic [BANK_W-1:0]  slot_bank   [SHEETS];
  logic [OFF_W-1:0]   slot_offset [SHEETS];
  logic [STAMP_W-1:0] slot_stamp  [SHEETS];
  logic [SHEETS-1:0]  slot_valid;
  logic [STAMP_W-1:0] use_stamp;

  logic [BANK_W-1:0]  key_bank;
  logic [OFF_W-1:0]   key_offset;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   victim;
  logic               best_valid;
  logic [STAMP_W-1:0] best_stamp;
  rsp_t               res;

  logic               accept;
  logic               out_free;
  logic               idx_ok;
  logic               last;
  logic [IDX_W-1:0]   req_slot;
  cmp_t               cmp;

  lssc_cmp u_cmp (
    .key_bank     (key_bank),
    .key_offset   (key_offset),
    .entry_valid  (slot_valid[cnt]),
    .entry_bank   (slot_bank[cnt]),
    .entry_offset (slot_offset[cnt]),
    .entry_stamp  (slot_stamp[cnt]),
    .best_stamp   (best_stamp),
    .result       (cmp)
  );

  always_comb begin
    req_stall = (state != S_IDLE);
    accept    = req_valid && (state == S_IDLE);
    out_free  = !rsp_valid || !rsp_stall;
    idx_ok    = ({1'b0, req.sheet_index} < (SHEET_W + 1)'(SHEETS));
    req_slot  = req.sheet_index[IDX_W-1:0];
    last      = (cnt == IDX_W'(SHEETS - 1));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_LOOKUP && req.bank_id != '0) begin
            state_next = S_HIT_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_HIT_SCAN: begin
        if (cmp.match) begin
          state_next = S_FINISH;
        end else if (last) begin
          state_next = (RESERVED >= SHEETS) ? S_FINISH : S_VICTIM_SCAN;
        end
      end
      S_VICTIM_SCAN: begin
        if (!slot_valid[cnt] || last) begin
          state_next = S_FILL;
        end
      end
      S_FILL:   state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      use_stamp  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_bank   <= req.bank_id;
            key_offset <= req.bank_offset;
            cnt        <= '0;
            if (req.action == ACT_LOOKUP) begin
              if (req.bank_id == '0) begin
                res <= '{status: ST_NULL, sheet: '0, load_request: 1'b0};
              end else begin
                use_stamp <= use_stamp + 1'b1;
              end
            end else if ((req.action == ACT_REGISTER || req.action == ACT_TOUCH) && idx_ok) begin
              use_stamp            <= use_stamp + 1'b1;
              slot_stamp[req_slot] <= use_stamp + 1'b1;
              if (req.action == ACT_REGISTER) begin
                slot_bank[req_slot]   <= req.bank_id;
                slot_offset[req_slot] <= '0;
                slot_valid[req_slot]  <= 1'b1;
              end
              res <= '{status: ST_DONE, sheet: req.sheet_index, load_request: 1'b0};
            end else begin
              res <= '{status: ST_BADINDEX, sheet: '0, load_request: 1'b0};
            end
          end
        end
        S_HIT_SCAN: begin
          if (cmp.match) begin
            slot_stamp[cnt] <= use_stamp;
            res             <= '{status: ST_HIT, sheet: SHEET_W'(cnt), load_request: 1'b0};
          end else if (last) begin
            // no eligible victim when every slot is reserved
            res        <= '{status: ST_NOSHEET, sheet: '0, load_request: 1'b0};
            cnt        <= IDX_W'(RESERVED);
            best_valid <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_VICTIM_SCAN: begin
          if (!slot_valid[cnt]) begin
            victim <= cnt;
          end else if (!best_valid || cmp.older) begin
            best_valid <= 1'b1;
            best_stamp <= slot_stamp[cnt];
            victim     <= cnt;
          end
          if (!last) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FILL: begin
          slot_bank[victim]   <= key_bank;
          slot_offset[victim] <= key_offset;
          slot_valid[victim]  <= 1'b1;
          slot_stamp[victim]  <= use_stamp;
          res <= '{status: ST_LOADED, sheet: SHEET_W'(victim), load_request: 1'b1};
        end
        S_FINISH: begin
          if (out_free) begin
            rsp <= res;
          end
        end
        default: ;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_load_means_loaded, !rsp_valid || !rsp.load_request || rsp.status == ST_LOADED)
  `ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `ASSERT_NEXT(a_fill_sets_valid, state == S_FILL, slot_valid[$past(victim)])

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lssc_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int BANK_POOL      = 4;
  localparam int OFF_POOL       = 3;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  lru_sheet_slot_cache dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the slot table
  logic [BANK_W-1:0]  line_bank   [SHEETS];
  logic [OFF_W-1:0]   line_offset [SHEETS];
  bit                 line_live   [SHEETS];
  logic [STAMP_W-1:0] line_age    [SHEETS];
  logic [STAMP_W-1:0] use_tick;

  req_t pending_items [$];
  rsp_t expected_rsps [$];

  logic [BANK_W-1:0] bank_pool [BANK_POOL];
  logic [OFF_W-1:0]  off_pool  [OFF_POOL];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int fault_count   = 0;
  int idle_cycles   = 0;

  function automatic rsp_t cache_predict(req_t item);
    rsp_t res;
    int   victim;
    bit   hit;
    bit   free_found;
    res        = '0;
    victim     = -1;
    hit        = 1'b0;
    free_found = 1'b0;
    case (item.action)
      ACT_LOOKUP: begin
        if (item.bank_id == '0) begin
          res.status = ST_NULL;
        end else begin
          use_tick = use_tick + 1'b1;
          for (int i = 0; i < SHEETS; i++) begin
            if (!hit && line_live[i] && line_bank[i] == item.bank_id &&
                line_offset[i] == item.bank_offset) begin
              hit         = 1'b1;
              line_age[i] = use_tick;
              res.status  = ST_HIT;
              res.sheet   = SHEET_W'(i);
            end
          end
          if (!hit) begin
            // first free slot wins, else strictly oldest stamp
            for (int i = RESERVED; i < SHEETS; i++) begin
              if (!free_found) begin
                if (!line_live[i]) begin
                  victim     = i;
                  free_found = 1'b1;
                end else if (victim < 0 || line_age[i] < line_age[victim]) begin
                  victim = i;
                end
              end
            end
            if (victim < 0) begin
              res.status = ST_NOSHEET;
            end else begin
              line_bank[victim]   = item.bank_id;
              line_offset[victim] = item.bank_offset;
              line_live[victim]   = 1'b1;
              line_age[victim]    = use_tick;
              res.status          = ST_LOADED;
              res.sheet           = SHEET_W'(victim);
              res.load_request    = 1'b1;
            end
          end
        end
      end
      ACT_REGISTER, ACT_TOUCH: begin
        if (item.sheet_index < SHEETS) begin
          use_tick = use_tick + 1'b1;
          if (item.action == ACT_REGISTER) begin
            line_bank[item.sheet_index]   = item.bank_id;
            line_offset[item.sheet_index] = '0;
            line_live[item.sheet_index]   = 1'b1;
          end
          line_age[item.sheet_index] = use_tick;
          res.status = ST_DONE;
          res.sheet  = item.sheet_index;
        end else begin
          res.status = ST_BADINDEX;
        end
      end
      default: begin
        res.status = ST_BADINDEX;
      end
    endcase
    return res;
  endfunction

  function automatic req_t random_item();
    req_t item;
    int   pick;
    pick             = $urandom_range(99);
    item.action      = ACT_LOOKUP;
    item.bank_id     = bank_pool[$urandom_range(BANK_POOL - 1)];
    item.bank_offset = off_pool[$urandom_range(OFF_POOL - 1)];
    item.sheet_index = SHEET_W'($urandom_range(SHEETS - 1));
    if (pick < 55) begin
      // lookup of a pooled key, most of the traffic
    end else if (pick < 63) begin
      item.bank_id     = {$urandom, $urandom};
      item.bank_offset = $urandom;
    end else if (pick < 67) begin
      item.bank_id     = '0;
      item.bank_offset = $urandom;
    end else if (pick < 77) begin
      item.action      = ACT_REGISTER;
      item.bank_offset = $urandom;
    end else if (pick < 87) begin
      item.action = ACT_TOUCH;
    end else if (pick < 93) begin
      item.action      = ($urandom_range(1) != 0) ? ACT_REGISTER : ACT_TOUCH;
      item.sheet_index = SHEET_W'($urandom_range(63));
    end else if (pick < 96) begin
      item.action      = ACT_UNKNOWN;
      item.bank_id     = {$urandom, $urandom};
      item.sheet_index = SHEET_W'($urandom_range(63));
    end else begin
      item.action  = ACT_REGISTER;
      item.bank_id = ($urandom_range(1) != 0) ? '0 : {$urandom, $urandom};
    end
    return item;
  endfunction

  task automatic add_item(logic [1:0] act, logic [BANK_W-1:0] bank,
                          logic [OFF_W-1:0] off, logic [SHEET_W-1:0] idx);
    req_t item;
    item.action      = act;
    item.bank_id     = bank;
    item.bank_offset = off;
    item.sheet_index = idx;
    pending_items.push_back(item);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < BANK_POOL; i++)
      bank_pool[i] = {$urandom, $urandom};
    off_pool[0] = '0;
    for (int i = 1; i < OFF_POOL; i++)
      off_pool[i] = $urandom;
    for (int i = 0; i < count; i++)
      pending_items.push_back(random_item());
    wait_drained();
  endtask

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s", $time, msg);
  endtask

  // Request side: predict on acceptance, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall)
        expected_rsps.push_back(cache_predict(req));
      if (!req_valid || !req_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side: check against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          note_fault($sformatf("unexpected result status %0d sheet %0d load %0d",
                               rsp.status, rsp.sheet, rsp.load_request));
        end else begin
          rsp_t want;
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status || rsp.sheet !== want.sheet ||
              rsp.load_request !== want.load_request)
            note_fault($sformatf(
              "result mismatch: expected status %0d sheet %0d load %0d, got %0d %0d %0d",
              want.status, want.sheet, want.load_request,
              rsp.status, rsp.sheet, rsp.load_request));
        end
      end
      if (hold_asked != hold_done) begin
        hold_left = LONG_HOLD;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SHEETS; i++) begin
      line_bank[i]   = '0;
      line_offset[i] = '0;
      line_live[i]   = 1'b0;
      line_age[i]    = '0;
    end
    use_tick = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 59;
    // null handle, full-width keys, fill of free slots, hit, LRU eviction
    add_item(ACT_LOOKUP,   '0,         '1,            '0);
    add_item(ACT_LOOKUP,   '1,         '1,            '1);
    add_item(ACT_LOOKUP,   '1,         '1,            '0);
    add_item(ACT_LOOKUP,   64'd1,      32'd0,         '0);
    add_item(ACT_LOOKUP,   64'd2,      32'd0,         '0);
    add_item(ACT_LOOKUP,   64'd3,      32'hFFFF_0000, '0);
    add_item(ACT_LOOKUP,   64'd4,      32'd7,         '0);
    add_item(ACT_LOOKUP,   64'd1,      32'd0,         '0);
    // register into a reserved slot drops the offset; hit it by lookup
    add_item(ACT_REGISTER, '1,         32'hDEAD_BEEF, 6'd0);
    add_item(ACT_LOOKUP,   '1,         32'd0,         '0);
    // a slot registered with the null handle never hits
    add_item(ACT_REGISTER, '0,         '0,            6'd7);
    add_item(ACT_LOOKUP,   '0,         '0,            '0);
    // touch a free slot and a live one, then force an eviction
    add_item(ACT_TOUCH,    '0,         '0,            6'd3);
    add_item(ACT_TOUCH,    '1,         '1,            6'd4);
    add_item(ACT_TOUCH,    '0,         '0,            6'd0);
    add_item(ACT_LOOKUP,   64'd5,      32'd1,         '0);
    add_item(ACT_LOOKUP,   64'd6,      32'd1,         '0);
    // out-of-range slot and unknown action
    add_item(ACT_REGISTER, 64'd9,      '0,            6'd8);
    add_item(ACT_TOUCH,    '0,         '0,            '1);
    add_item(ACT_REGISTER, '0,         '0,            '1);
    add_item(ACT_UNKNOWN,  64'd1,      32'd0,         6'd1);
    add_item(ACT_LOOKUP,   64'h8000_0000_0000_0000, 32'h8000_0000, '1);
    wait_drained();

    run_random(150);

    // hold the result side off while items keep coming
    hold_asked++;
    run_random(40);

    send_idle_pct = 59;
    recv_idle_pct = 9;
    run_random(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(120);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_rsps.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
